FILE: src/tpoac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpoac_pkg
// Shared widths, pipeline depths and sideband types of the opening angle
// cosine block.
// ----------------------------------------------------------------------------
package tpoac_pkg;

    localparam int E_W         = 16;  // cluster energy
    localparam int P_W         = 16;  // cluster position
    localparam int D_W         = 17;  // per-axis difference
    localparam int PROD_W      = 34;  // signed product of two differences
    localparam int SQ_IN_W     = 34;  // squared length
    localparam int DOT_W       = 35;  // signed dot product
    localparam int MAG_W       = 34;  // dot product magnitude
    localparam int LEN_W       = 17;  // vector length
    localparam int DEN_W       = 34;  // product of the two lengths
    localparam int NUM_W       = 52;  // dividend and shifted divisor
    localparam int Q_W         = 17;  // quotient bits produced by the divider
    localparam int COS_W       = 16;  // Q1.15 cosine
    localparam int IDX_W       = 2;   // apex index
    localparam int FRAC_SHIFT  = 16;  // dot * 65536 in the rounded quotient

    localparam int SQRT_STAGES = LEN_W;
    localparam int DIV_STAGES  = Q_W + 1;

    localparam logic [IDX_W-1:0] APEX_0 = 2'd0;
    localparam logic [IDX_W-1:0] APEX_1 = 2'd1;
    localparam logic [IDX_W-1:0] APEX_2 = 2'd2;

    localparam logic signed [COS_W-1:0] COS_MAX = 16'sh7FFF;
    localparam logic signed [COS_W-1:0] COS_MIN = 16'sh8000;

    typedef struct packed {
        logic [IDX_W-1:0]        apex;
        logic signed [DOT_W-1:0] dot;
    } t_sq_side;

    typedef struct packed {
        logic [IDX_W-1:0] apex;
        logic             neg;
        logic             zero;
        logic [LEN_W-1:0] len1;
        logic [LEN_W-1:0] len2;
    } t_div_side;

endpackage

FILE: src/tpoac_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpoac_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tpoac_isqrt (
    input  logic                          i_clk,
    input  logic [tpoac_pkg::SQ_IN_W-1:0] i_value,
    output logic [tpoac_pkg::LEN_W-1:0]   o_root
);
    import tpoac_pkg::*;

    logic [SQ_IN_W-1:0] r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0]   r_root [SQRT_STAGES];

    genvar g;
    generate
        for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
            localparam int B = SQRT_STAGES - 1 - g;
            logic [SQ_IN_W-1:0] w_rem;
            logic [LEN_W-1:0]   w_root;
            logic [SQ_IN_W+1:0] w_trial;

            if (g == 0) begin : g_first
                assign w_rem  = i_value;
                assign w_root = '0;
            end else begin : g_next
                assign w_rem  = r_rem[g-1];
                assign w_root = r_root[g-1];
            end

            // The trial term is (2 * root + 2^B) * 2^B.
            assign w_trial = ({{(SQ_IN_W+1-LEN_W){1'b0}}, w_root, 1'b0}
                             + ((SQ_IN_W+2)'(1) << B)) << B;

            always_ff @(posedge i_clk) begin
                if ({2'b00, w_rem} >= w_trial) begin
                    r_rem[g]  <= w_rem - w_trial[SQ_IN_W-1:0];
                    r_root[g] <= w_root | (LEN_W'(1) << B);
                end else begin
                    r_rem[g]  <= w_rem;
                    r_root[g] <= w_root;
                end
            end
        end
    endgenerate

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

FILE: src/tpoac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpoac_div
// Pipelined restoring divider for the rounded cosine quotient.
// ----------------------------------------------------------------------------
module tpoac_div (
    input  logic                        i_clk,
    input  logic [tpoac_pkg::MAG_W-1:0] i_mag,
    input  logic [tpoac_pkg::DEN_W-1:0] i_den,
    output logic [tpoac_pkg::Q_W-1:0]   o_quot,
    output logic                        o_ovf
);
    import tpoac_pkg::*;

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [DEN_W:0]   r_dvs [DIV_STAGES];
    logic [Q_W-1:0]   r_q   [DIV_STAGES];
    logic             r_ovf [DIV_STAGES];

    // Dividend is mag * 65536 + den and divisor is 2 * den, which rounds
    // the quotient to nearest with halves away from zero.
    logic [NUM_W-1:0] w_num;
    logic [DEN_W:0]   w_dvs;
    assign w_num = (NUM_W'(i_mag) << FRAC_SHIFT) + NUM_W'(i_den);
    assign w_dvs = {i_den, 1'b0};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_num;
        r_dvs[0] <= w_dvs;
        r_q[0]   <= '0;
        r_ovf[0] <= w_num >= (NUM_W'(w_dvs) << Q_W);
    end

    genvar g;
    generate
        for (g = 1; g < DIV_STAGES; g++) begin : g_stage
            localparam int J = DIV_STAGES - 1 - g;
            logic [NUM_W-1:0] w_sub;
            assign w_sub = NUM_W'(r_dvs[g-1]) << J;

            always_ff @(posedge i_clk) begin
                r_dvs[g] <= r_dvs[g-1];
                r_ovf[g] <= r_ovf[g-1];
                if (r_rem[g-1] >= w_sub) begin
                    r_rem[g] <= r_rem[g-1] - w_sub;
                    r_q[g]   <= r_q[g-1] | (Q_W'(1) << J);
                end else begin
                    r_rem[g] <= r_rem[g-1];
                    r_q[g]   <= r_q[g-1];
                end
            end
        end
    endgenerate

    assign o_quot = r_q[DIV_STAGES-1];
    assign o_ovf  = r_ovf[DIV_STAGES-1];

endmodule

FILE: src/three_point_opening_angle_cosine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_opening_angle_cosine
// Apex selection, difference vectors, lengths and opening angle cosine of
// three charge clusters.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is taken at each rising clock edge with start high and busy
// low. It carries three cluster energies and positions. The block picks the
// most energetic cluster as apex (lowest index on ties), forms the two
// difference vectors to the other clusters in index order, and returns both
// lengths (floored square roots), the apex index and the Q1.15 cosine of the
// angle between the vectors, saturated; the cosine is zero when a length is
// zero.
// Throughput is one transaction per clock cycle outside reset. Between the
// accepting edge and o_done lie three stages for selection, products and
// sums, 17 square root stages (one root bit each), one length product stage,
// 18 divider stages (a load stage, then one quotient bit each) and the output
// register. The result stays on the ports for exactly one cycle with o_done
// high; the receiver cannot stall, so nothing is held.
// busy is high only while reset is asserted. Synchronous reset clears every
// valid bit, so transactions in flight are dropped.
// ----------------------------------------------------------------------------
module three_point_opening_angle_cosine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [tpoac_pkg::E_W-1:0]          i_energy_a,
    input  logic [tpoac_pkg::E_W-1:0]          i_energy_b,
    input  logic [tpoac_pkg::E_W-1:0]          i_energy_c,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_x_a,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_y_a,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_z_a,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_x_b,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_y_b,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_z_b,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_x_c,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_y_c,
    input  logic signed [tpoac_pkg::P_W-1:0]   i_pos_z_c,
    output logic                               o_done,
    output logic signed [tpoac_pkg::COS_W-1:0] o_cos_angle,
    output logic [tpoac_pkg::LEN_W-1:0]        o_length_first,
    output logic [tpoac_pkg::LEN_W-1:0]        o_length_second,
    output logic [tpoac_pkg::IDX_W-1:0]        o_apex_index
);
    import tpoac_pkg::*;

    // The pipeline takes a transaction in every cycle outside reset.
    assign busy = ~i_rst_n;

    logic w_accept;
    assign w_accept = start & ~busy;

    // ---------------- Stage 1: apex selection and differences -------------
    logic [IDX_W-1:0]        n_apex;
    logic [E_W-1:0]          w_e_best;
    logic signed [P_W-1:0]   w_ax, w_ay, w_az;
    logic signed [P_W-1:0]   w_ox1, w_oy1, w_oz1, w_ox2, w_oy2, w_oz2;

    always_comb begin
        n_apex   = APEX_0;
        w_e_best = i_energy_a;
        if (i_energy_b > w_e_best) begin
            n_apex   = APEX_1;
            w_e_best = i_energy_b;
        end
        if (i_energy_c > w_e_best) begin
            n_apex = APEX_2;
        end
    end

    // The other two clusters are taken in index order.
    always_comb begin
        case (n_apex)
            APEX_1: begin
                w_ax = i_pos_x_b; w_ay = i_pos_y_b; w_az = i_pos_z_b;
                w_ox1 = i_pos_x_a; w_oy1 = i_pos_y_a; w_oz1 = i_pos_z_a;
                w_ox2 = i_pos_x_c; w_oy2 = i_pos_y_c; w_oz2 = i_pos_z_c;
            end
            APEX_2: begin
                w_ax = i_pos_x_c; w_ay = i_pos_y_c; w_az = i_pos_z_c;
                w_ox1 = i_pos_x_a; w_oy1 = i_pos_y_a; w_oz1 = i_pos_z_a;
                w_ox2 = i_pos_x_b; w_oy2 = i_pos_y_b; w_oz2 = i_pos_z_b;
            end
            default: begin
                w_ax = i_pos_x_a; w_ay = i_pos_y_a; w_az = i_pos_z_a;
                w_ox1 = i_pos_x_b; w_oy1 = i_pos_y_b; w_oz1 = i_pos_z_b;
                w_ox2 = i_pos_x_c; w_oy2 = i_pos_y_c; w_oz2 = i_pos_z_c;
            end
        endcase
    end

    logic                    r_v1;
    logic [IDX_W-1:0]        r_apex1;
    logic signed [D_W-1:0]   r_d1 [3];
    logic signed [D_W-1:0]   r_d2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
        r_apex1 <= n_apex;
        r_d1[0] <= D_W'(w_ox1) - D_W'(w_ax);
        r_d1[1] <= D_W'(w_oy1) - D_W'(w_ay);
        r_d1[2] <= D_W'(w_oz1) - D_W'(w_az);
        r_d2[0] <= D_W'(w_ox2) - D_W'(w_ax);
        r_d2[1] <= D_W'(w_oy2) - D_W'(w_ay);
        r_d2[2] <= D_W'(w_oz2) - D_W'(w_az);
    end

    // ---------------- Stage 2: per-axis products ---------------------------
    logic                     r_v2;
    logic [IDX_W-1:0]         r_apex2;
    logic signed [PROD_W-1:0] r_sq1 [3];
    logic signed [PROD_W-1:0] r_sq2 [3];
    logic signed [PROD_W-1:0] r_cr  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_apex2 <= r_apex1;
        for (int k = 0; k < 3; k++) begin
            r_sq1[k] <= PROD_W'(r_d1[k]) * PROD_W'(r_d1[k]);
            r_sq2[k] <= PROD_W'(r_d2[k]) * PROD_W'(r_d2[k]);
            r_cr[k]  <= PROD_W'(r_d1[k]) * PROD_W'(r_d2[k]);
        end
    end

    // ---------------- Stage 3: squared lengths and dot product -------------
    logic                    r_v3;
    logic [SQ_IN_W-1:0]      r_s1, r_s2;
    t_sq_side                r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        // Squares are nonnegative and below 2^32, so their low bits add up.
        r_s1 <= SQ_IN_W'(r_sq1[0]) + SQ_IN_W'(r_sq1[1]) + SQ_IN_W'(r_sq1[2]);
        r_s2 <= SQ_IN_W'(r_sq2[0]) + SQ_IN_W'(r_sq2[1]) + SQ_IN_W'(r_sq2[2]);
        r_side3.apex <= r_apex2;
        r_side3.dot  <= DOT_W'(r_cr[0]) + DOT_W'(r_cr[1]) + DOT_W'(r_cr[2]);
    end

    // ---------------- Square roots -----------------------------------------
    logic [LEN_W-1:0] w_len1, w_len2;

    tpoac_isqrt u_sqrt_first (
        .i_clk   (i_clk),
        .i_value (r_s1),
        .o_root  (w_len1)
    );

    tpoac_isqrt u_sqrt_second (
        .i_clk   (i_clk),
        .i_value (r_s2),
        .o_root  (w_len2)
    );

    logic     r_sq_v    [SQRT_STAGES];
    t_sq_side r_sq_side [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (k == 0) begin
                r_sq_v[k] <= r_v3;
            end else begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
            if (k == 0) begin
                r_sq_side[k] <= r_side3;
            end else begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // ---------------- Stage 4: length product and dot magnitude ------------
    t_sq_side         w_sq_out;
    logic             r_v4;
    logic [MAG_W-1:0] r_mag;
    logic [DEN_W-1:0] r_den;
    t_div_side        r_side4;

    assign w_sq_out = r_sq_side[SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_sq_v[SQRT_STAGES-1];
        end
        r_den <= DEN_W'(w_len1) * DEN_W'(w_len2);
        if (w_sq_out.dot < 0) begin
            r_mag <= MAG_W'(-w_sq_out.dot);
        end else begin
            r_mag <= MAG_W'(w_sq_out.dot);
        end
        r_side4.apex <= w_sq_out.apex;
        r_side4.neg  <= w_sq_out.dot < 0;
        r_side4.zero <= (w_len1 == '0) || (w_len2 == '0);
        r_side4.len1 <= w_len1;
        r_side4.len2 <= w_len2;
    end

    // ---------------- Division ---------------------------------------------
    logic [Q_W-1:0] w_quot;
    logic           w_ovf;

    tpoac_div u_div (
        .i_clk  (i_clk),
        .i_mag  (r_mag),
        .i_den  (r_den),
        .o_quot (w_quot),
        .o_ovf  (w_ovf)
    );

    logic      r_dv_v    [DIV_STAGES];
    t_div_side r_dv_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (k == 0) begin
                r_dv_v[k] <= r_v4;
            end else begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
            if (k == 0) begin
                r_dv_side[k] <= r_side4;
            end else begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ---------------- Output stage: sign and saturation --------------------
    t_div_side               w_dv_out;
    logic signed [COS_W-1:0] n_cos;

    assign w_dv_out = r_dv_side[DIV_STAGES-1];

    always_comb begin
        if (w_dv_out.zero) begin
            n_cos = '0;
        end else if (w_dv_out.neg) begin
            if (w_ovf || (w_quot > Q_W'(32768))) begin
                n_cos = COS_MIN;
            end else begin
                n_cos = COS_W'(-w_quot);
            end
        end else begin
            if (w_ovf || (w_quot > Q_W'(32767))) begin
                n_cos = COS_MAX;
            end else begin
                n_cos = COS_W'(w_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_dv_v[DIV_STAGES-1];
        end
        o_cos_angle     <= n_cos;
        o_length_first  <= w_dv_out.len1;
        o_length_second <= w_dv_out.len2;
        o_apex_index    <= w_dv_out.apex;
    end

    // ---------------- Assertions -------------------------------------------
    // Every accepted transaction comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##40 o_done)
        else $error("result strobe missing after fixed latency");

    // A zero length always forces a zero cosine.
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_length_first == '0 || o_length_second == '0))
        |-> (o_cos_angle == '0))
        else $error("nonzero cosine with a zero length");

    // The apex index stays within the three clusters.
    a_apex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_apex_index == APEX_0 || o_apex_index == APEX_1 ||
                    o_apex_index == APEX_2))
        else $error("apex index out of range");

endmodule

FILE: test/tb_three_point_opening_angle_cosine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_point_opening_angle_cosine
// Self-checking testbench of the opening angle cosine block. A behavioral
// predictor computes apex, lengths and the rounded, saturated cosine for
// every accepted transaction; a monitor compares each strobed result with
// the oldest prediction. Directed corner cases come first, then random
// transactions under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb_three_point_opening_angle_cosine;
    import tpoac_pkg::*;

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLES = 200000;

    // One expected result per transaction.
    typedef struct {
        logic signed [COS_W-1:0] cos_angle;
        logic [LEN_W-1:0]        len_first;
        logic [LEN_W-1:0]        len_second;
        logic [IDX_W-1:0]        apex;
    } t_angle_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [E_W-1:0] i_energy_a = '0, i_energy_b = '0, i_energy_c = '0;
    logic signed [P_W-1:0] i_pos_x_a = '0, i_pos_y_a = '0, i_pos_z_a = '0;
    logic signed [P_W-1:0] i_pos_x_b = '0, i_pos_y_b = '0, i_pos_z_b = '0;
    logic signed [P_W-1:0] i_pos_x_c = '0, i_pos_y_c = '0, i_pos_z_c = '0;
    logic o_done;
    logic signed [COS_W-1:0] o_cos_angle;
    logic [LEN_W-1:0] o_length_first, o_length_second;
    logic [IDX_W-1:0] o_apex_index;

    t_angle_result pending_angles[$];
    int mismatch_count = 0;
    int result_count = 0;
    int sent_count = 0;
    int cycle_count = 0;
    int idle_percent = 0;

    three_point_opening_angle_cosine dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Floor of the square root, bit by bit.
    function automatic logic [LEN_W-1:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[LEN_W-1:0];
    endfunction

    // Predicts the result of one transaction.
    function automatic t_angle_result predict_angle(
        input logic [E_W-1:0] e[3],
        input logic signed [P_W-1:0] p[3][3]
    );
        t_angle_result r;
        int apex, n, oth[2];
        longint d1, d2, dot;
        longint unsigned s1, s2, den, mag, q;
        apex = 0;
        n = 0;
        s1 = 0;
        s2 = 0;
        dot = 0;
        for (int i = 1; i < 3; i++) if (e[i] > e[apex]) apex = i;
        for (int i = 0; i < 3; i++) if (i != apex) oth[n++] = i;
        for (int k = 0; k < 3; k++) begin
            d1 = longint'(p[oth[0]][k]) - longint'(p[apex][k]);
            d2 = longint'(p[oth[1]][k]) - longint'(p[apex][k]);
            s1 += d1 * d1;
            s2 += d2 * d2;
            dot += d1 * d2;
        end
        r.len_first = floor_sqrt(s1);
        r.len_second = floor_sqrt(s2);
        r.apex = apex[IDX_W-1:0];
        r.cos_angle = '0;
        if (r.len_first != 0 && r.len_second != 0) begin
            den = longint'(r.len_first) * longint'(r.len_second);
            mag = (dot < 0) ? -dot : dot;
            q = (mag * 65536 + den) / (2 * den);
            if (dot < 0) r.cos_angle = (q > 32768) ? COS_MIN : COS_W'(-q);
            else r.cos_angle = (q > 32767) ? COS_MAX : COS_W'(q);
        end
        return r;
    endfunction

    // Sends one transaction, honoring the idle rate, and records its prediction.
    task automatic send_clusters(input logic [E_W-1:0] e[3],
                                 input logic signed [P_W-1:0] p[3][3]);
        while ($urandom_range(99) < idle_percent) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        {i_energy_a, i_energy_b, i_energy_c} <= {e[0], e[1], e[2]};
        {i_pos_x_a, i_pos_y_a, i_pos_z_a} <= {p[0][0], p[0][1], p[0][2]};
        {i_pos_x_b, i_pos_y_b, i_pos_z_b} <= {p[1][0], p[1][1], p[1][2]};
        {i_pos_x_c, i_pos_y_c, i_pos_z_c} <= {p[2][0], p[2][1], p[2][2]};
        do @(posedge i_clk); while (busy);
        pending_angles.push_back(predict_angle(e, p));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [E_W-1:0] e[3];
        logic signed [P_W-1:0] p[3][3];
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(9);
            for (int i = 0; i < 3; i++) begin
                // Some transactions force energy ties, some small coordinates.
                e[i] = (mode == 0) ? 16'(1000 * $urandom_range(1)) : 16'($urandom);
                for (int k = 0; k < 3; k++)
                    p[i][k] = (mode < 3) ? P_W'($signed($urandom_range(8)) - 4)
                                         : P_W'($urandom);
            end
            if (mode == 3) p[1] = p[0];  // zero length unless cluster c is apex
            send_clusters(e, p);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Corner cases: ties, extreme coordinates, zero lengths and saturation.
    task automatic test_directed();
        logic [E_W-1:0] e[3];
        logic signed [P_W-1:0] p[3][3];
        idle_percent = 0;
        for (int c = 0; c < 20; c++) begin
            e = '{16'd5, 16'd5, 16'd5};
            if (c % 4 == 1) e = '{16'd0, 16'hFFFF, 16'hFFFF};
            if (c % 4 == 2) e = '{16'd1, 16'd2, 16'hFFFF};
            if (c % 4 == 3) e = '{16'hFFFF, 16'd0, 16'd0};
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) p[i][k] = '0;
            case (c / 4)
                0: ;  // everything coincident, both lengths zero
                1: begin  // opposite extremes, longest vectors
                    p[0] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
                    p[1] = '{16'sh8000, 16'sh8000, 16'sh8000};
                    p[2] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
                end
                2: begin  // collinear, cosine near plus or minus one
                    p[0] = '{16'sd1, 16'sd1, 16'sd0};
                    p[1] = '{16'sd2, 16'sd2, 16'sd0};
                    p[2] = '{-16'sd3, -16'sd3, 16'sd0};
                end
                3: begin  // one zero-length vector unless b is apex
                    p[1] = '{16'sd100, -16'sd7, 16'sd3};
                end
                default: begin  // right angle when cluster a is the apex
                    p[1] = '{16'sh8000, 16'sd0, 16'sd0};
                    p[2] = '{16'sd0, 16'sh7FFF, 16'sd0};
                end
            endcase
            send_clusters(e, p);
        end
    endtask

    task automatic test_sender_idle_rarely();
        idle_percent = 27;
        send_random(310);
        // Let the pipeline run empty before going on.
        drain_results();
    endtask

    task automatic test_sender_idle_often();
        idle_percent = 63;
        send_random(310);
    endtask

    task automatic test_back_to_back();
        idle_percent = 0;
        send_random(310);
    endtask

    // Results are only valid for the cycle o_done is high.
    always @(posedge i_clk) begin
        t_angle_result want;
        if (i_rst_n && o_done) begin
            result_count++;
            if (pending_angles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result at cycle %0d", cycle_count);
            end else begin
                want = pending_angles.pop_front();
                if (o_cos_angle !== want.cos_angle || o_length_first !== want.len_first ||
                    o_length_second !== want.len_second || o_apex_index !== want.apex) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected cos %0d len %0d/%0d apex %0d, ",
                                  "got cos %0d len %0d/%0d apex %0d"},
                                 want.cos_angle, want.len_first, want.len_second, want.apex,
                                 o_cos_angle, o_length_first, o_length_second, o_apex_index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_sender_idle_rarely();
        test_sender_idle_often();
        test_back_to_back();
        drain_results();
        $display("Covered %0d transactions: ties, extremes, zero lengths, random clusters.",
                 sent_count);
        $display("Checked %0d results, %0d mismatches.", result_count, mismatch_count);
        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/tpoac_pkg.sv
src/tpoac_isqrt.sv
src/tpoac_div.sv
src/three_point_opening_angle_cosine.sv
test/tb_three_point_opening_angle_cosine.sv
